/* rtl/fpa_pkg.sv */
// Shared constants for the first-fit partition allocator.
`default_nettype none

package fpa_pkg;

  localparam int MemUnitsDef   = 512;
  localparam int TableDepthDef = 64;
  localparam int AmountW       = 10;
  localparam int OwnerW        = 8;
  localparam int StatusW       = 3;

  localparam logic CMD_RELEASE  = 1'b0;
  localparam logic CMD_ALLOCATE = 1'b1;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_NOFIT   = 3'd1;
  localparam logic [StatusW-1:0] ST_NOOWNER = 3'd2;
  localparam logic [StatusW-1:0] ST_EXCEEDS = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

endpackage

`default_nettype wire

/* rtl/first_fit_partition_allocator_core.sv */
// Top level of the first-fit partition allocator with its segment table in RAM.
//
//   channel | signals                            | direction
//   input   | in_valid, in_ready, cmd, owner, amount | into the block
//   output  | out_valid, out_ready, status, block_start, segments_used | out of the block
//
// The time a request takes grows with the index of the found entry and with the number
// of entries moved. A refused request stops once the found entry and its neighbors are
// read, a request that matches no entry scans all count entries, and an allocation of zero
// units is answered without a scan.
// The segment RAM has a single read port: one entry is read per cycle.
// After reset, the initial free segment is written before requests are taken.
// A new request is taken only when the previous one is finished; a result waits in the
// output register until its transfer, and the block holds its last step while it waits.
`default_nettype none

module first_fit_partition_allocator_core #(
  parameter int MEM_UNITS   = fpa_pkg::MemUnitsDef,
  parameter int TABLE_DEPTH = fpa_pkg::TableDepthDef
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               cmd,
  input  wire logic [fpa_pkg::OwnerW-1:0]         owner,
  input  wire logic [fpa_pkg::AmountW-1:0]        amount,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [fpa_pkg::StatusW-1:0]        status,
  output logic      [$clog2(MEM_UNITS)-1:0]       block_start,
  output logic      [$clog2(TABLE_DEPTH+1)-1:0]   segments_used
);

  localparam int SW  = $clog2(MEM_UNITS);
  localparam int LW  = $clog2(MEM_UNITS + 1);
  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CNW = $clog2(TABLE_DEPTH + 1);
  localparam int PW  = CNW + 1;
  localparam int AMW = fpa_pkg::AmountW;
  localparam int CW  = (LW > AMW) ? LW : AMW;
  localparam int EW  = SW + LW + fpa_pkg::OwnerW + 1;

  typedef struct packed {
    logic [SW-1:0]              start;
    logic [LW-1:0]              len;
    logic [fpa_pkg::OwnerW-1:0] owner;
    logic                       free;
  } entry_t;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_NEIGH = 8'b0000_1000,
    S_COPY  = 8'b0001_0000,
    S_WR1   = 8'b0010_0000,
    S_WR2   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                       state;
  logic [CNW-1:0]               count;
  logic                         cmd_r;
  logic [fpa_pkg::OwnerW-1:0]   owner_r;
  logic [AMW-1:0]               amount_r;
  logic [CNW-1:0]               ptr;
  logic                         sc_pend;
  entry_t                       prev;
  entry_t                       ent;
  logic [CNW-1:0]               idx;
  logic [fpa_pkg::StatusW-1:0]  st_r;
  logic [SW-1:0]                where_r;
  logic [CNW-1:0]               cnt_new;
  logic [PW-1:0]                cp_src;
  logic [PW-1:0]                cp_lim;
  logic                         cp_up;
  logic                         cp_two;
  logic                         cp_pend;
  logic [IW-1:0]                cp_dst;
  logic                         w1_en;
  logic [IW-1:0]                w1_addr;
  entry_t                       w1_data;
  logic                         w2_en;
  logic [IW-1:0]                w2_addr;
  entry_t                       w2_data;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd;

  assign rd = entry_t'(ram_rdata);

  fpa_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(EW'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [CW-1:0] amt_c;
  logic          scan_match;
  logic          cp_rd;

  assign amt_c = CW'(amount_r);
  assign scan_match = (cmd_r == fpa_pkg::CMD_ALLOCATE) ?
                      (rd.free && (CW'(rd.len) >= amt_c)) :
                      (!rd.free && (rd.owner == owner_r));
  assign cp_rd = cp_up ? (cp_src >= cp_lim) : (cp_src <= cp_lim);
  assign in_ready = (state == S_IDLE);

  // Decision once the found entry and both neighbors are known.
  logic [fpa_pkg::StatusW-1:0] d_st;
  logic [CNW-1:0]              d_cnt;
  logic [PW-1:0]               d_src;
  logic [PW-1:0]               d_lim;
  logic                        d_up;
  logic                        d_two;
  logic                        d_w1_en;
  logic [IW-1:0]               d_w1_addr;
  entry_t                      d_w1_data;
  logic                        d_w2_en;
  logic [IW-1:0]               d_w2_addr;
  entry_t                      d_w2_data;

  always_comb begin
    logic [PW-1:0] i_p;
    logic [PW-1:0] cnt_p;
    logic [IW-1:0] i_a;
    logic          lf;
    logic          rf;
    logic          full;
    logic [SW-1:0] split_start;
    i_p         = PW'(idx);
    cnt_p       = PW'(count);
    i_a         = idx[IW-1:0];
    lf          = (idx != '0) && prev.free;
    rf          = ((i_p + PW'(1)) < cnt_p) && rd.free;
    full        = cnt_p >= PW'(TABLE_DEPTH);
    split_start = SW'(CW'(ent.start) + amt_c);
    d_st        = fpa_pkg::ST_OK;
    d_cnt       = count;
    d_src       = '0;
    d_lim       = PW'(1);
    d_up        = 1'b1;
    d_two       = 1'b0;
    d_w1_en     = 1'b0;
    d_w1_addr   = i_a;
    d_w1_data   = ent;
    d_w2_en     = 1'b0;
    d_w2_addr   = i_a;
    d_w2_data   = ent;
    if (cmd_r == fpa_pkg::CMD_ALLOCATE) begin
      if (CW'(ent.len) == amt_c) begin
        d_w1_en   = 1'b1;
        d_w1_data = '{start: ent.start, len: LW'(amount_r), owner: owner_r, free: 1'b0};
      end else if (full) begin
        d_st = fpa_pkg::ST_FULL;
      end else begin
        d_src     = cnt_p - PW'(1);
        d_lim     = i_p + PW'(1);
        d_w1_en   = 1'b1;
        d_w1_addr = IW'(i_a + IW'(1));
        d_w1_data = '{start: split_start, len: LW'(ent.len - LW'(amount_r)),
                      owner: '0, free: 1'b1};
        d_w2_en   = 1'b1;
        d_w2_data = '{start: ent.start, len: LW'(amount_r), owner: owner_r, free: 1'b0};
        d_cnt     = CNW'(count + CNW'(1));
      end
    end else if ((amt_c == '0) || (amt_c > CW'(ent.len))) begin
      d_st = fpa_pkg::ST_EXCEEDS;
    end else if (amt_c == CW'(ent.len)) begin
      d_w1_en = 1'b1;
      d_up    = 1'b0;
      d_lim   = cnt_p - PW'(1);
      if (lf && rf) begin
        d_w1_addr = IW'(i_a - IW'(1));
        d_w1_data = '{start: prev.start, len: LW'(prev.len + ent.len + rd.len),
                      owner: '0, free: 1'b1};
        d_src     = i_p + PW'(2);
        d_two     = 1'b1;
        d_cnt     = CNW'(count - CNW'(2));
      end else if (lf) begin
        d_w1_addr = IW'(i_a - IW'(1));
        d_w1_data = '{start: prev.start, len: LW'(prev.len + ent.len), owner: '0, free: 1'b1};
        d_src     = i_p + PW'(1);
        d_cnt     = CNW'(count - CNW'(1));
      end else if (rf) begin
        d_w1_data = '{start: ent.start, len: LW'(ent.len + rd.len), owner: '0, free: 1'b1};
        d_src     = i_p + PW'(2);
        d_cnt     = CNW'(count - CNW'(1));
      end else begin
        d_w1_data = '{start: ent.start, len: ent.len, owner: '0, free: 1'b1};
        d_up      = 1'b1;
        d_src     = '0;
        d_lim     = PW'(1);
      end
    end else if (lf) begin
      d_w1_en   = 1'b1;
      d_w1_addr = IW'(i_a - IW'(1));
      d_w1_data = '{start: prev.start, len: LW'(prev.len + LW'(amount_r)),
                    owner: '0, free: 1'b1};
      d_w2_en   = 1'b1;
      d_w2_data = '{start: split_start, len: LW'(ent.len - LW'(amount_r)),
                    owner: ent.owner, free: 1'b0};
    end else if (full) begin
      d_st = fpa_pkg::ST_FULL;
    end else begin
      d_src     = cnt_p - PW'(1);
      d_lim     = i_p + PW'(1);
      d_w1_en   = 1'b1;
      d_w1_addr = IW'(i_a + IW'(1));
      d_w1_data = '{start: split_start, len: LW'(ent.len - LW'(amount_r)),
                    owner: ent.owner, free: 1'b0};
      d_w2_en   = 1'b1;
      d_w2_data = '{start: ent.start, len: LW'(amount_r), owner: '0, free: 1'b1};
      d_cnt     = CNW'(count + CNW'(1));
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cp_dst;
    ram_wdata = rd;
    ram_raddr = ptr[IW-1:0];
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{start: '0, len: LW'(MEM_UNITS), owner: '0, free: 1'b1};
      end
      S_COPY: begin
        ram_we    = cp_pend;
        ram_raddr = cp_src[IW-1:0];
      end
      S_WR1: begin
        ram_we    = w1_en;
        ram_waddr = w1_addr;
        ram_wdata = w1_data;
      end
      S_WR2: begin
        ram_we    = w2_en;
        ram_waddr = w2_addr;
        ram_wdata = w2_data;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      count   <= CNW'(1);
      sc_pend <= 1'b0;
      cp_pend <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd;
            owner_r  <= owner;
            amount_r <= amount;
            ptr      <= '0;
            sc_pend  <= 1'b0;
            if ((cmd == fpa_pkg::CMD_ALLOCATE) && (amount == '0)) begin
              st_r    <= fpa_pkg::ST_NOFIT;
              where_r <= '0;
              state   <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          sc_pend <= 1'b1;
          if (!sc_pend) begin
            ptr <= CNW'(ptr + CNW'(1));
          end else if (scan_match) begin
            idx   <= CNW'(ptr - CNW'(1));
            ent   <= rd;
            state <= S_NEIGH;
          end else if (ptr == count) begin
            st_r    <= (cmd_r == fpa_pkg::CMD_ALLOCATE) ?
                       fpa_pkg::ST_NOFIT : fpa_pkg::ST_NOOWNER;
            where_r <= '0;
            state   <= S_DONE;
          end else begin
            prev <= rd;
            ptr  <= CNW'(ptr + CNW'(1));
          end
        end
        S_NEIGH: begin
          st_r    <= d_st;
          where_r <= (d_st == fpa_pkg::ST_OK) ? ent.start : '0;
          cnt_new <= d_cnt;
          cp_src  <= d_src;
          cp_lim  <= d_lim;
          cp_up   <= d_up;
          cp_two  <= d_two;
          cp_pend <= 1'b0;
          w1_en   <= d_w1_en && (d_st == fpa_pkg::ST_OK);
          w1_addr <= d_w1_addr;
          w1_data <= d_w1_data;
          w2_en   <= d_w2_en && (d_st == fpa_pkg::ST_OK);
          w2_addr <= d_w2_addr;
          w2_data <= d_w2_data;
          if (d_st == fpa_pkg::ST_OK) begin
            state <= S_COPY;
          end else begin
            state <= S_DONE;
          end
        end
        S_COPY: begin
          cp_pend <= cp_rd;
          if (cp_rd) begin
            if (cp_up) begin
              cp_dst <= IW'(cp_src + PW'(1));
              cp_src <= PW'(cp_src - PW'(1));
            end else begin
              cp_dst <= cp_two ? IW'(cp_src - PW'(2)) : IW'(cp_src - PW'(1));
              cp_src <= PW'(cp_src + PW'(1));
            end
          end
          if (!cp_rd && !cp_pend) begin
            state <= S_WR1;
          end
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          count <= cnt_new;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_valid     <= 1'b1;
      status        <= st_r;
      block_start   <= where_r;
      segments_used <= count;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> ((count != '0) && (PW'(count) <= PW'(TABLE_DEPTH))))
    else $error("Segment count left its legal range.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_NEIGH) || (state == S_IDLE)) |-> !ram_we)
    else $error("Table written while it is being searched.");

  a_copy_no_collide: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COPY) && cp_pend && cp_rd) |-> (cp_dst != cp_src[IW-1:0]))
    else $error("Entry move reads and writes the same entry in one cycle.");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_NEIGH) && (d_st != fpa_pkg::ST_OK)) |=> ($stable(count) && (state == S_DONE)))
    else $error("A refused request changed the table.");

endmodule

`default_nettype wire

/* rtl/fpa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* tb/sv/first_fit_partition_allocator_core_tb.sv */
// Testbench for the first-fit partition allocator: random and directed requests checked against a table model.
`default_nettype none

module first_fit_partition_allocator_core_tb;

  localparam int Units = 512;
  localparam int Depth = 64;

  typedef struct packed {
    logic       cmd;
    logic [7:0] owner;
    logic [9:0] amount;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] block_start;
    logic [6:0] segments_used;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [7:0] owner = '0;
  logic [9:0] amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [8:0] block_start;
  logic [6:0] segments_used;

  first_fit_partition_allocator_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .owner(owner), .amount(amount), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .block_start(block_start), .segments_used(segments_used)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int seg_start [Depth];
  int seg_len [Depth];
  int seg_owner [Depth];
  bit seg_free [Depth];
  int seg_count;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  bit stimulus_done = 0;

  function automatic void table_reset();
    for (int k = 0; k < Depth; k++) begin
      seg_start[k] = 0;
      seg_len[k] = 0;
      seg_owner[k] = 0;
      seg_free[k] = 0;
    end
    seg_len[0] = Units;
    seg_free[0] = 1;
    seg_count = 1;
  endfunction

  function automatic void open_slot(int k);
    for (int j = seg_count; j > k; j--) begin
      seg_start[j] = seg_start[j-1];
      seg_len[j] = seg_len[j-1];
      seg_owner[j] = seg_owner[j-1];
      seg_free[j] = seg_free[j-1];
    end
    seg_count++;
  endfunction

  function automatic void close_slot(int k);
    for (int j = k; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_len[j] = seg_len[j+1];
      seg_owner[j] = seg_owner[j+1];
      seg_free[j] = seg_free[j+1];
    end
    seg_count--;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int i;
    int where;
    logic [2:0] st;
    int amt;
    int own;
    where = 0;
    amt = r.amount;
    own = r.owner;
    st = fpa_pkg::ST_NOFIT;
    if (r.cmd == fpa_pkg::CMD_ALLOCATE) begin
      if (amt != 0) begin
        for (i = 0; i < seg_count; i++) begin
          if (seg_free[i] && seg_len[i] >= amt) break;
        end
        if (i < seg_count) begin
          if (seg_len[i] != amt && seg_count >= Depth) begin
            st = fpa_pkg::ST_FULL;
          end else begin
            if (seg_len[i] != amt) begin
              open_slot(i + 1);
              seg_start[i+1] = seg_start[i] + amt;
              seg_len[i+1] = seg_len[i] - amt;
              seg_owner[i+1] = 0;
              seg_free[i+1] = 1;
            end
            seg_len[i] = amt;
            seg_owner[i] = own;
            seg_free[i] = 0;
            where = seg_start[i];
            st = fpa_pkg::ST_OK;
          end
        end
      end
    end else begin
      for (i = 0; i < seg_count; i++) begin
        if (!seg_free[i] && seg_owner[i] == own) break;
      end
      if (i >= seg_count) begin
        st = fpa_pkg::ST_NOOWNER;
      end else if (amt == 0 || amt > seg_len[i]) begin
        st = fpa_pkg::ST_EXCEEDS;
      end else if (amt == seg_len[i]) begin
        where = seg_start[i];
        seg_free[i] = 1;
        seg_owner[i] = 0;
        if (i + 1 < seg_count && seg_free[i+1]) begin
          seg_len[i] += seg_len[i+1];
          close_slot(i + 1);
        end
        if (i > 0 && seg_free[i-1]) begin
          seg_len[i-1] += seg_len[i];
          close_slot(i);
        end
        st = fpa_pkg::ST_OK;
      end else if (i > 0 && seg_free[i-1]) begin
        where = seg_start[i];
        seg_len[i-1] += amt;
        seg_start[i] += amt;
        seg_len[i] -= amt;
        st = fpa_pkg::ST_OK;
      end else if (seg_count >= Depth) begin
        st = fpa_pkg::ST_FULL;
      end else begin
        where = seg_start[i];
        open_slot(i + 1);
        seg_start[i+1] = seg_start[i] + amt;
        seg_len[i+1] = seg_len[i] - amt;
        seg_owner[i+1] = own;
        seg_free[i+1] = 0;
        seg_start[i] = where;
        seg_len[i] = amt;
        seg_owner[i] = 0;
        seg_free[i] = 1;
        st = fpa_pkg::ST_OK;
      end
    end
    if (st != fpa_pkg::ST_OK) where = 0;
    a.status = st;
    a.block_start = where[8:0];
    a.segments_used = seg_count[6:0];
    return a;
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void push_request(logic c, int o, int amt);
    request_t r;
    r.cmd = c;
    r.owner = o[7:0];
    r.amount = amt[9:0];
    pending_requests.push_back(r);
  endfunction

  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(apply_request({cmd, owner, amount}));
        in_valid <= 1'b0;
        send_gap = gap_length();
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          request_t r;
          r = pending_requests.pop_front();
          cmd <= r.cmd;
          owner <= r.owner;
          amount <= r.amount;
          in_valid <= 1'b1;
        end
      end
    end
  end

  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        answer_t e;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: status %0d", status);
        end else begin
          e = expected_answers.pop_front();
          if (status !== e.status || block_start !== e.block_start ||
              segments_used !== e.segments_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                       e.status, e.block_start, e.segments_used,
                       status, block_start, segments_used);
          end
        end
        recv_gap = gap_length();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int o;
    table_reset();
    push_request(fpa_pkg::CMD_ALLOCATE, 8'h00, 0);
    push_request(fpa_pkg::CMD_RELEASE, 8'hff, 5);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'hff, 1023);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'hff, 513);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'h01, 512);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'h02, 1);
    push_request(fpa_pkg::CMD_RELEASE, 8'h01, 0);
    push_request(fpa_pkg::CMD_RELEASE, 8'h01, 513);
    push_request(fpa_pkg::CMD_RELEASE, 8'h01, 100);
    push_request(fpa_pkg::CMD_RELEASE, 8'h01, 412);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'haa, 10);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'h55, 20);
    push_request(fpa_pkg::CMD_ALLOCATE, 8'haa, 30);
    push_request(fpa_pkg::CMD_RELEASE, 8'h55, 5);
    push_request(fpa_pkg::CMD_RELEASE, 8'haa, 10);
    push_request(fpa_pkg::CMD_RELEASE, 8'h55, 15);
    push_request(fpa_pkg::CMD_RELEASE, 8'haa, 30);
    for (int k = 0; k < 70; k++) push_request(fpa_pkg::CMD_ALLOCATE, k, 1 + (k % 3));
    for (int k = 0; k < 70; k += 2) push_request(fpa_pkg::CMD_RELEASE, k, 1);
    for (int k = 0; k < 70; k++) push_request(fpa_pkg::CMD_RELEASE, k, 3);
    for (int n = 0; n < 310; n++) begin
      int p;
      p = $urandom_range(99);
      o = $urandom_range(15);
      if (p < 5) o = $urandom_range(255);
      if (p < 50) push_request(fpa_pkg::CMD_ALLOCATE, o, $urandom_range(1, 40));
      else if (p < 85) push_request(fpa_pkg::CMD_RELEASE, o, $urandom_range(1, 40));
      else push_request(1'($urandom_range(1)), o, $urandom_range(1023));
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_requests.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("first_fit_partition_allocator_core_tb passed");
    else
      $display("first_fit_partition_allocator_core_tb failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("first_fit_partition_allocator_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
